/* design/b32h_pkg.sv */
// b32h_pkg: shared types, constants and the digit lookup for the base32hex decoder
// no dependencies
`default_nettype none

package b32h_pkg;

  localparam int CharWidth   = 8;
  localparam int DigitWidth  = 5;
  localparam int StoreWidth  = 7;
  localparam int CountWidth  = 3;
  localparam int StatusWidth = 2;

  localparam logic [CharWidth-1:0] PAD_CHAR = 8'h3D;

  localparam logic [StatusWidth-1:0] STATUS_OK       = 2'd0;
  localparam logic [StatusWidth-1:0] STATUS_BAD_CHAR = 2'd1;
  localparam logic [StatusWidth-1:0] STATUS_BAD_LEN  = 2'd2;

  typedef struct packed {
    logic                   ok;
    logic [DigitWidth-1:0]  value;
  } digit_t;

  typedef struct packed {
    logic [CharWidth-1:0]   data_byte;
    logic                   byte_valid;
    logic                   string_done;
    logic [StatusWidth-1:0] status;
  } result_t;

  function automatic digit_t digit_lookup(input logic [CharWidth-1:0] c);
    digit_t d;
    d.ok    = 1'b1;
    d.value = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d.value = 5'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h56) begin
      d.value = 5'(c - 8'h41 + 8'd10);
    end else if (c >= 8'h61 && c <= 8'h76) begin
      d.value = 5'(c - 8'h61 + 8'd10);
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

/* design/b32h_core.sv */
// b32h_core: per-string decode state and the combinational step for one character
// depends on b32h_pkg
`default_nettype none

module b32h_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           step,
  input  wire logic [b32h_pkg::CharWidth-1:0] char_code,
  input  wire logic                           end_of_string,
  output logic                                produce,
  output b32h_pkg::result_t                   result
);
  import b32h_pkg::*;

  logic [StoreWidth-1:0] bit_store, bit_store_next;
  logic [CountWidth-1:0] bit_count, bit_count_next;
  logic [CountWidth-1:0] char_phase, char_phase_next;
  logic                  pad_seen, pad_seen_next;
  logic                  bad_char_seen, bad_char_seen_next;

  digit_t                 digit;
  logic [11:0]            acc;
  logic [3:0]             total;
  logic [CountWidth-1:0]  remain;
  logic                   have_byte;
  logic [CharWidth-1:0]   byte_out;

  always_comb begin
    digit              = digit_lookup(char_code);
    acc                = {bit_store, digit.value};
    total              = {1'b0, bit_count} + 4'd5;
    remain             = 3'(total - 4'd8);
    have_byte          = 1'b0;
    byte_out           = '0;
    bit_store_next     = bit_store;
    bit_count_next     = bit_count;
    char_phase_next    = char_phase;
    pad_seen_next      = pad_seen;
    bad_char_seen_next = bad_char_seen;

    if (!pad_seen && !bad_char_seen) begin
      if (char_code == PAD_CHAR) begin
        pad_seen_next = 1'b1;
      end else if (!digit.ok) begin
        bad_char_seen_next = 1'b1;
      end else begin
        char_phase_next = char_phase + 3'd1;
        if (total >= 4'd8) begin
          have_byte      = 1'b1;
          byte_out       = 8'(acc >> remain);
          bit_store_next = 7'(acc & ((12'd1 << remain) - 12'd1));
          bit_count_next = remain;
        end else begin
          bit_store_next = 7'(acc);
          bit_count_next = 3'(total);
        end
      end
    end

    produce            = have_byte || end_of_string;
    result.data_byte   = byte_out;
    result.byte_valid  = have_byte;
    result.string_done = end_of_string;
    result.status      = STATUS_OK;
    if (end_of_string) begin
      if (bad_char_seen_next) begin
        result.status = STATUS_BAD_CHAR;
      end else if (char_phase_next == 3'd1 || char_phase_next == 3'd3 ||
                   char_phase_next == 3'd6) begin
        result.status = STATUS_BAD_LEN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_store     <= '0;
      bit_count     <= '0;
      char_phase    <= '0;
      pad_seen      <= 1'b0;
      bad_char_seen <= 1'b0;
    end else if (step) begin
      if (end_of_string) begin
        // string closed: back to the reset state
        bit_store     <= '0;
        bit_count     <= '0;
        char_phase    <= '0;
        pad_seen      <= 1'b0;
        bad_char_seen <= 1'b0;
      end else begin
        bit_store     <= bit_store_next;
        bit_count     <= bit_count_next;
        char_phase    <= char_phase_next;
        pad_seen      <= pad_seen_next;
        bad_char_seen <= bad_char_seen_next;
      end
    end
  end

endmodule

`default_nettype wire

/* design/base32hex_stream_decoder_top.sv */
// base32hex_stream_decoder_top: input register, decode step and result register
// result registered from the decode step on the input register; throughput 1 character
// per cycle; a stalled result holds the character in the input register and blocks new requests
// reset (rst, synchronous) empties both registers and clears the decode state at once
// depends on b32h_pkg and b32h_core
`default_nettype none

module base32hex_stream_decoder_top (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [b32h_pkg::CharWidth-1:0]   char_code,
  input  wire logic                             end_of_string,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [b32h_pkg::CharWidth-1:0]        data_byte,
  output logic                                  byte_valid,
  output logic                                  string_done,
  output logic [b32h_pkg::StatusWidth-1:0]      status
);
  import b32h_pkg::*;

  logic                 held_valid;
  logic [CharWidth-1:0] held_char;
  logic                 held_last;
  logic                 advance;
  logic                 produce;
  result_t              step_result;
  result_t              out_result;

  assign advance  = held_valid && (!out_valid || out_ready);
  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_char <= char_code;
      held_last <= end_of_string;
    end
  end

  b32h_core u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .char_code     (held_char),
    .end_of_string (held_last),
    .produce       (produce),
    .result        (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= produce;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && produce) begin
      out_result <= step_result;
    end
  end

  assign data_byte   = out_result.data_byte;
  assign byte_valid  = out_result.byte_valid;
  assign string_done = out_result.string_done;
  assign status      = out_result.status;

`ifndef SYNTHESIS
  a_bad_char_no_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_BAD_CHAR |-> !byte_valid)
    else $error("byte emitted on a string closed by a bad character");

  a_mid_string_is_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && !string_done |-> byte_valid && status == STATUS_OK)
    else $error("result without byte or with status before string end");

  a_no_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> data_byte == '0)
    else $error("data byte not zero on a closing result without byte");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 2'd3)
    else $error("undefined status code");
`endif

endmodule

`default_nettype wire

/* sim/base32hex_stream_decoder_checker.sv */
// base32hex_stream_decoder_checker: watches both channels of the decoder, predicts every
// result from the accepted characters and compares them field by field
// depends on b32h_pkg
module base32hex_stream_decoder_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [b32h_pkg::CharWidth-1:0] char_code,
  input  logic                           end_of_string,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [b32h_pkg::CharWidth-1:0] data_byte,
  input  logic                           byte_valid,
  input  logic                           string_done,
  input  logic [b32h_pkg::StatusWidth-1:0] status,
  output int                             fail_count,
  output int                             results_owed,
  output int                             strings_closed,
  output int                             bytes_decoded,
  output int                             bad_char_closes,
  output int                             bad_len_closes
);
  import b32h_pkg::*;

  result_t                 decoded_q[$];
  logic [StoreWidth-1:0]   held_bits;
  logic [CountWidth-1:0]   held_count;
  logic [2:0]              digit_phase;
  logic                    pad_hit;
  logic                    bad_hit;
  int                      mismatches;
  int                      closes;
  int                      bytes_seen;
  int                      char_closes;
  int                      len_closes;

  initial begin
    fail_count      = 0;
    results_owed    = 0;
    strings_closed  = 0;
    bytes_decoded   = 0;
    bad_char_closes = 0;
    bad_len_closes  = 0;
    mismatches      = 0;
    closes          = 0;
    bytes_seen      = 0;
    char_closes     = 0;
    len_closes      = 0;
  end

  // {ok, value}
  function automatic logic [5:0] char_digit(input logic [CharWidth-1:0] c);
    logic [5:0] d;
    d = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = {1'b1, 5'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h56) begin
      d = {1'b1, 5'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h76) begin
      d = {1'b1, 5'(c - 8'h57)};
    end
    return d;
  endfunction

  task automatic clear_string;
    held_bits   = '0;
    held_count  = '0;
    digit_phase = '0;
    pad_hit     = 1'b0;
    bad_hit     = 1'b0;
  endtask

  task automatic decode_char(input logic [CharWidth-1:0] c, input logic last);
    logic [5:0]  d;
    logic [11:0] acc;
    logic [3:0]  n;
    logic        emit;
    result_t     r;
    emit = 1'b0;
    r    = '0;
    if (!pad_hit && !bad_hit) begin
      if (c == PAD_CHAR) begin
        pad_hit = 1'b1;
      end else begin
        d = char_digit(c);
        if (!d[5]) begin
          bad_hit = 1'b1;
        end else begin
          acc = {held_bits, d[4:0]};
          n   = 4'(held_count) + 4'd5;
          if (n >= 4'd8) begin
            n           = n - 4'd8;
            r.data_byte = 8'(acc >> n);
            emit        = 1'b1;
            acc         = acc & ((12'd1 << n) - 12'd1);
          end
          held_bits   = acc[StoreWidth-1:0];
          held_count  = n[CountWidth-1:0];
          digit_phase = digit_phase + 3'd1;
        end
      end
    end
    r.byte_valid = emit;
    if (last) begin
      r.string_done = 1'b1;
      if (bad_hit) begin
        r.status = STATUS_BAD_CHAR;
      end else if (digit_phase == 3'd1 || digit_phase == 3'd3 || digit_phase == 3'd6) begin
        r.status = STATUS_BAD_LEN;
      end else begin
        r.status = STATUS_OK;
      end
      clear_string();
    end
    if (emit || last) begin
      decoded_q.push_back(r);
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < 40) begin
      $display("mismatch at %0t: %s got %0h, expected %0h", $time, what, got, want);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      clear_string();
      decoded_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          report_mismatch("result with nothing owed, data_byte", data_byte, 0);
        end else begin
          want = decoded_q.pop_front();
          if (data_byte !== want.data_byte) begin
            report_mismatch("data_byte", data_byte, want.data_byte);
          end
          if (byte_valid !== want.byte_valid) begin
            report_mismatch("byte_valid", byte_valid, want.byte_valid);
          end
          if (string_done !== want.string_done) begin
            report_mismatch("string_done", string_done, want.string_done);
          end
          if (status !== want.status) begin
            report_mismatch("status", status, want.status);
          end
        end
        if (byte_valid === 1'b1) begin
          bytes_seen++;
        end
        if (string_done === 1'b1) begin
          closes++;
          if (status == STATUS_BAD_CHAR) begin
            char_closes++;
          end
          if (status == STATUS_BAD_LEN) begin
            len_closes++;
          end
        end
      end
      if (in_valid && in_ready) begin
        decode_char(char_code, end_of_string);
      end
    end
    fail_count      <= mismatches;
    results_owed    <= decoded_q.size();
    strings_closed  <= closes;
    bytes_decoded   <= bytes_seen;
    bad_char_closes <= char_closes;
    bad_len_closes  <= len_closes;
  end

endmodule

/* sim/base32hex_stream_decoder_top_tb.sv */
// base32hex_stream_decoder_top_tb: clock, reset and string stimulus for the decoder,
// with bursty requests and a stalling receiver; the verdict comes from the checker
// depends on b32h_pkg, base32hex_stream_decoder_top and base32hex_stream_decoder_checker
module base32hex_stream_decoder_top_tb;
  import b32h_pkg::*;

  localparam int ItemTarget = 550;
  localparam int CycleLimit = 200000;
  localparam int DrainWait  = 12;

  logic                   clk           = 1'b0;
  logic                   rst           = 1'b1;
  logic                   in_valid      = 1'b0;
  logic [CharWidth-1:0]   char_code     = '0;
  logic                   end_of_string = 1'b0;
  logic                   out_ready     = 1'b0;
  logic                   in_ready;
  logic                   out_valid;
  logic [CharWidth-1:0]   data_byte;
  logic                   byte_valid;
  logic                   string_done;
  logic [StatusWidth-1:0] status;

  int fail_count;
  int results_owed;
  int strings_closed;
  int bytes_decoded;
  int bad_char_closes;
  int bad_len_closes;
  int chars_sent  = 0;
  int burst_left  = 0;
  int cycle_count = 0;
  int mode_left   = 0;
  logic [1:0] stall_mode = 2'd0;
  logic [CharWidth-1:0] text_q[$];

  always #5 clk = ~clk;

  base32hex_stream_decoder_top dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .char_code     (char_code),
    .end_of_string (end_of_string),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .data_byte     (data_byte),
    .byte_valid    (byte_valid),
    .string_done   (string_done),
    .status        (status)
  );

  base32hex_stream_decoder_checker u_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .char_code       (char_code),
    .end_of_string   (end_of_string),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .data_byte       (data_byte),
    .byte_valid      (byte_valid),
    .string_done     (string_done),
    .status          (status),
    .fail_count      (fail_count),
    .results_owed    (results_owed),
    .strings_closed  (strings_closed),
    .bytes_decoded   (bytes_decoded),
    .bad_char_closes (bad_char_closes),
    .bad_len_closes  (bad_len_closes)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("[base32hex_stream_decoder_top] ERROR");
      $finish;
    end
  end

  // receiver: free-flowing, coin-toss, mostly stalled or lightly stalled stretches
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= 2'($urandom_range(0, 3));
      mode_left  <= $urandom_range(20, 150);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      2'd0: begin
        out_ready <= 1'b1;
      end
      2'd1: begin
        out_ready <= 1'($urandom_range(0, 1));
      end
      2'd2: begin
        out_ready <= ($urandom_range(0, 7) == 0);
      end
      default: begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
    endcase
  end

  function automatic logic [CharWidth-1:0] digit_char(input int v);
    logic [CharWidth-1:0] c;
    if (v < 10) begin
      c = 8'(8'h30 + v);
    end else if ($urandom_range(0, 1) == 1) begin
      c = 8'(8'h41 + v - 10);
    end else begin
      c = 8'(8'h61 + v - 10);
    end
    return c;
  endfunction

  // any byte that is neither a digit nor the pad, often one just outside a digit range
  function automatic logic [CharWidth-1:0] junk_char();
    logic [CharWidth-1:0] c;
    logic [CharWidth-1:0] edges[6];
    edges = '{8'h2F, 8'h3A, 8'h40, 8'h57, 8'h60, 8'h77};
    if ($urandom_range(0, 3) == 0) begin
      c = edges[$urandom_range(0, 5)];
    end else begin
      c = 8'($urandom_range(0, 255));
      while ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h56) ||
             (c >= 8'h61 && c <= 8'h76) || c == PAD_CHAR) begin
        c = 8'($urandom_range(0, 255));
      end
    end
    return c;
  endfunction

  task automatic send_char(input logic [CharWidth-1:0] c, input logic last);
    int gap;
    in_valid      <= 1'b1;
    char_code     <= c;
    end_of_string <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chars_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 12);
    end
  endtask

  task automatic send_text;
    for (int i = 0; i < text_q.size(); i++) begin
      send_char(text_q[i], i == text_q.size() - 1);
    end
    text_q.delete();
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      text_q.push_back(s[i]);
    end
  endtask

  initial begin
    int kind;
    int ndig;
    int bad_at;
    int npad;
    int lens[5];
    lens = '{0, 2, 4, 5, 7};

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // empty decode, all-ones bytes, closing digit completing a byte
    queue_text("=");
    send_text();
    queue_text("VVVVVVVV");
    send_text();
    queue_text("00");
    send_text();
    // bad lengths
    queue_text("a");
    send_text();
    queue_text("vvv");
    send_text();
    // invalid characters, characters ignored after the pad, and a lone invalid character
    text_q = '{8'h39, 8'hFF, PAD_CHAR};
    send_text();
    queue_text("Av=");
    text_q.push_back(8'h00);
    send_text();
    text_q.push_back(8'h00);
    send_text();

    while (chars_sent < ItemTarget) begin
      kind = $urandom_range(0, 9);
      if (kind == 9) begin
        repeat ($urandom_range(1, 10)) text_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        if (kind < 5) begin
          ndig = 8 * $urandom_range(0, 2) + lens[$urandom_range(0, 4)];
        end else if ($urandom_range(0, 3) == 0) begin
          ndig = $urandom_range(0, 3);
        end else begin
          ndig = $urandom_range(1, 24);
        end
        bad_at = (kind == 7 || kind == 8) ? $urandom_range(0, ndig) : -1;
        for (int i = 0; i <= ndig; i++) begin
          if (i == bad_at) begin
            text_q.push_back(junk_char());
          end
          if (i < ndig) begin
            text_q.push_back(digit_char($urandom_range(0, 31)));
          end
        end
        if ($urandom_range(0, 2) == 0) begin
          npad = $urandom_range(1, 6);
          repeat (npad) text_q.push_back(PAD_CHAR);
          if ($urandom_range(0, 1) == 1) begin
            repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom_range(0, 255)));
          end
        end
        if (text_q.size() == 0) begin
          text_q.push_back(PAD_CHAR);
        end
      end
      send_text();
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);

    $display("sent %0d characters; %0d strings closed, %0d bytes decoded",
             chars_sent, strings_closed, bytes_decoded);
    $display("closed with invalid character: %0d, with bad length: %0d",
             bad_char_closes, bad_len_closes);
    if (fail_count == 0) begin
      $display("[base32hex_stream_decoder_top] OK");
    end else begin
      $display("[base32hex_stream_decoder_top] ERROR");
    end
    $finish;
  end

endmodule
